// ----- rtl/core/rgbpk_pkg.sv -----
// Shared types, constants and pixel encoding for the RGB planar masked packer.
package rgbpk_pkg;

    localparam int unsigned MAX_ROW_WIDTH = 4096;
    localparam int unsigned ROW_WIDTH_W   = 13;
    localparam int unsigned PADDR_W       = 4;
    localparam int unsigned PDATA_W       = 32;
    localparam int unsigned BURST_MAX     = 4;
    localparam int unsigned PAIR_MIN_WIDTH = 16;

    localparam logic [1:0] REG_TWO_BITS    = 2'd0;
    localparam logic [1:0] REG_TRANSPARENT = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH   = 2'd2;

    localparam logic [23:0] COLOR_BLACK   = 24'h000000;
    localparam logic [23:0] COLOR_MAGENTA = 24'hFF00FF;
    localparam logic [23:0] COLOR_BLUE    = 24'h0000FF;
    localparam logic [23:0] COLOR_GREEN   = 24'h00FF00;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_MAX = ROW_WIDTH_W'(MAX_ROW_WIDTH);
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(16);
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_PAIR = ROW_WIDTH_W'(PAIR_MIN_WIDTH);

    typedef struct packed {
        logic                   two_bits;
        logic                   transparent;
        logic [ROW_WIDTH_W-1:0] row_width;
    } cfg_t;

    // Pixel code for the selected depth.
    function automatic logic [1:0] pixel_code(input logic [23:0] color, input logic two_bits);
        logic [1:0] code;
        if (two_bits) begin
            if (color == COLOR_BLACK) begin
                code = 2'd0;
            end else if (color == COLOR_BLUE) begin
                code = 2'd1;
            end else if (color == COLOR_GREEN) begin
                code = 2'd2;
            end else begin
                code = 2'd3;
            end
        end else begin
            code = (color != COLOR_BLACK) ? 2'd1 : 2'd0;
        end
        return code;
    endfunction

endpackage

// ----- rtl/core/rgbpk_cfg.sv -----
// APB-style configuration registers for the packer.
module rgbpk_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbpk_pkg::PADDR_W-1:0]    paddr,
    input  logic [rgbpk_pkg::PDATA_W-1:0]    pwdata,
    output logic [rgbpk_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    output rgbpk_pkg::cfg_t                  cfg
);
    import rgbpk_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic                   wr_en;
    logic [1:0]             reg_index;
    logic [ROW_WIDTH_W-1:0] width_in;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];
    assign width_in  = pwdata[ROW_WIDTH_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                REG_TWO_BITS:    cfg_next.two_bits = pwdata[0];
                REG_TRANSPARENT: cfg_next.transparent = pwdata[0];
                REG_ROW_WIDTH:
                begin
                    // clamp oversize widths on write
                    cfg_next.row_width = (width_in > ROW_WIDTH_MAX) ? ROW_WIDTH_MAX : width_in;
                end
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.two_bits    <= 1'b1;
            cfg_reg.transparent <= 1'b0;
            cfg_reg.row_width   <= ROW_WIDTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_TWO_BITS:    prdata = PDATA_W'(cfg_reg.two_bits);
            REG_TRANSPARENT: prdata = PDATA_W'(cfg_reg.transparent);
            REG_ROW_WIDTH:   prdata = PDATA_W'(cfg_reg.row_width);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/rgb_to_planar_masked_packer_unit.sv -----
// Top level of the RGB to planar masked packer.
// The first byte of an item's burst is offered in the cycle after the item is accepted.
// Throughput: one pixel per cycle while out_ready is high and each item yields at most one
// byte; an item that completes a mask/data burst of 2 or 4 bytes holds the input until
// its last byte is taken, as the single burst output register drains one byte a cycle.
// Reset: registers return to 2 bpp, opaque, row width 16; accumulators and held pair clear.
module rgb_to_planar_masked_packer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbpk_pkg::PADDR_W-1:0]    paddr,
    input  logic [rgbpk_pkg::PDATA_W-1:0]    pwdata,
    output logic [rgbpk_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [23:0]                      pixel_color,
    input  logic                             row_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             row_last,
    output logic                             run_last
);
    import rgbpk_pkg::*;

    cfg_t cfg;

    logic [7:0] data_accum_reg, data_accum_next;
    logic [7:0] mask_accum_reg, mask_accum_next;
    logic [2:0] pixel_slot_reg, pixel_slot_next;
    logic [7:0] held_data_reg, held_data_next;
    logic [7:0] held_mask_reg, held_mask_next;
    logic       held_valid_reg, held_valid_next;

    logic [7:0] burst_byte_reg [BURST_MAX];
    logic [7:0] burst_byte_next [BURST_MAX];
    logic [2:0] burst_count_reg, burst_count_next;
    logic [1:0] burst_idx_reg, burst_idx_next;
    logic       burst_row_end_reg, burst_row_end_next;

    logic       accept;
    logic       last_byte;
    logic       clear_px;
    logic [1:0] code;
    logic [2:0] shift;
    logic [1:0] ones;
    logic [2:0] last_slot;
    logic       done;
    logic [7:0] data_new;
    logic [7:0] mask_new;

    rgbpk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_valid = (burst_count_reg != 3'd0);
    assign last_byte = ({1'b0, burst_idx_reg} + 3'd1) == burst_count_reg;
    assign in_ready  = !out_valid || (out_ready && last_byte);
    assign accept    = in_valid && in_ready;

    assign out_byte = burst_byte_reg[burst_idx_reg];
    assign run_last = last_byte;
    assign row_last = last_byte && burst_row_end_reg;

    always_comb
    begin
        clear_px = cfg.transparent && (pixel_color == COLOR_MAGENTA);
        code     = pixel_code(pixel_color, cfg.two_bits);
        if (cfg.two_bits)
        begin
            shift     = {pixel_slot_reg[1:0], 1'b0};
            ones      = 2'd3;
            last_slot = 3'd3;
        end
        else
        begin
            shift     = pixel_slot_reg;
            ones      = 2'd1;
            last_slot = 3'd7;
        end
        if (clear_px)
        begin
            data_new = data_accum_reg;
            mask_new = mask_accum_reg;
        end
        else
        begin
            data_new = data_accum_reg | ({6'd0, code} << shift);
            mask_new = mask_accum_reg | ({6'd0, ones} << shift);
        end
        done = !((pixel_slot_reg < last_slot) && !row_end);
    end

    always_comb
    begin
        data_accum_next    = data_accum_reg;
        mask_accum_next    = mask_accum_reg;
        pixel_slot_next    = pixel_slot_reg;
        held_data_next     = held_data_reg;
        held_mask_next     = held_mask_reg;
        held_valid_next    = held_valid_reg;
        burst_byte_next    = burst_byte_reg;
        burst_count_next   = burst_count_reg;
        burst_idx_next     = burst_idx_reg;
        burst_row_end_next = burst_row_end_reg;

        // advance the burst on each taken byte
        if (out_valid && out_ready)
        begin
            if (last_byte)
            begin
                burst_count_next = 3'd0;
                burst_idx_next   = 2'd0;
            end
            else
            begin
                burst_idx_next = burst_idx_reg + 2'd1;
            end
        end

        if (accept)
        begin
            if (!done)
            begin
                data_accum_next = data_new;
                mask_accum_next = mask_new;
                pixel_slot_next = pixel_slot_reg + 3'd1;
            end
            else
            begin
                data_accum_next    = 8'd0;
                mask_accum_next    = 8'd0;
                pixel_slot_next    = 3'd0;
                burst_row_end_next = row_end;
                burst_idx_next     = 2'd0;
                if (held_valid_reg)
                begin
                    // emit the pair: both masks, then both data bytes
                    burst_byte_next[0] = held_mask_reg;
                    burst_byte_next[1] = mask_new;
                    burst_byte_next[2] = held_data_reg;
                    burst_byte_next[3] = data_new;
                    burst_count_next   = 3'd4;
                    held_valid_next    = 1'b0;
                    held_data_next     = 8'd0;
                    held_mask_next     = 8'd0;
                end
                else if (!cfg.transparent)
                begin
                    burst_byte_next[0] = data_new;
                    burst_count_next   = 3'd1;
                end
                else if ((cfg.row_width >= ROW_WIDTH_PAIR) && !row_end)
                begin
                    // hold the first group of a pair
                    held_data_next  = data_new;
                    held_mask_next  = mask_new;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    burst_byte_next[0] = mask_new;
                    burst_byte_next[1] = data_new;
                    burst_count_next   = 3'd2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_accum_reg  <= 8'd0;
            mask_accum_reg  <= 8'd0;
            pixel_slot_reg  <= 3'd0;
            held_data_reg   <= 8'd0;
            held_mask_reg   <= 8'd0;
            held_valid_reg  <= 1'b0;
            burst_count_reg <= 3'd0;
            burst_idx_reg   <= 2'd0;
        end
        else
        begin
            data_accum_reg  <= data_accum_next;
            mask_accum_reg  <= mask_accum_next;
            pixel_slot_reg  <= pixel_slot_next;
            held_data_reg   <= held_data_next;
            held_mask_reg   <= held_mask_next;
            held_valid_reg  <= held_valid_next;
            burst_count_reg <= burst_count_next;
            burst_idx_reg   <= burst_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_byte_reg    <= burst_byte_next;
        burst_row_end_reg <= burst_row_end_next;
    end

endmodule
